// ===== sv/centered_moving_average_block_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the centered moving average block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CENTERED_MOVING_AVERAGE_BLOCK_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_BLOCK_ASSERT_SVH

// property holds in every cycle
`define CMA_ASSERT_HOLDS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CMA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths, constants and word types of the centered moving average.
// ----------------------------------------------------------------------------
package cma_pkg;

  // sample width and fixed register widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 6;
  localparam int POS_W    = 7;

  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(127);
  localparam logic [CFG_W-1:0] LEN_MIN   = CFG_W'(3);
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // input word
  typedef struct packed {
    sample_t sample;
    logic    block_end;
  } in_word_t;

  // output word
  typedef struct packed {
    sample_t average;
    logic    final_result;
    logic    rejected;
  } out_word_t;

endpackage

// ===== sv/cma_cell.sv =====
// ----------------------------------------------------------------------------
// cma_cell
// One stage of the sample ring: holds a sample and takes its neighbor's
// sample whenever the ring moves.
// ----------------------------------------------------------------------------
module cma_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  cma_pkg::sample_t  d_i,
  output cma_pkg::sample_t  q_o
);
  import cma_pkg::*;

  sample_t value_q;

  // sample storage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (shift_i) begin
      value_q <= d_i;
    end
  end

  assign q_o = value_q;

endmodule

// ===== sv/cma_div.sv =====
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in SAMPLE_W bits, so the top bits start as remainder.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int DIV_W = 7
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [cma_pkg::SAMPLE_W+DIV_W-1:0]    num_i,
  input  logic [DIV_W-1:0]                      den_i,
  output logic                                  done_o,
  output logic [cma_pkg::SAMPLE_W-1:0]          quot_o
);
  import cma_pkg::*;

  localparam int STEP_W = $clog2(SAMPLE_W + 1);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] steps_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  rem_d;
  logic [DIV_W-1:0]  den_q;
  logic [SAMPLE_W-1:0] quo_q;
  logic [DIV_W:0]    trial;
  logic              fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[SAMPLE_W-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign rem_d = fits ? DIV_W'(trial - {1'b0, den_q}) : DIV_W'(trial);

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else if (start_i) begin
      run_q   <= 1'b1;
      done_q  <= 1'b0;
      steps_q <= STEP_W'(SAMPLE_W);
    end else if (run_q) begin
      steps_q <= steps_q - STEP_W'(1);
      if (steps_q == STEP_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[SAMPLE_W+DIV_W-1:SAMPLE_W];
      quo_q <= num_i[SAMPLE_W-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SAMPLE_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/centered_moving_average_block.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average_block
// Rounded centered moving average over blocks of signed samples.
// ----------------------------------------------------------------------------
// Samples enter a ring of 2*MAX_HALF+2 cells. A sample that completes no
// window (block still shorter than the window and not ending) is only
// stored in the ring. A sample that completes a window starts a ring pass
// that stores running suffix sums in a small memory, then each result it
// releases goes through memory read, difference, divider load, SAMPLE_W
// bit-serial divider steps, done and output load. In steady streaming each
// sample therefore takes an accept, a ring pass and one result, and the
// input stays stalled until then, also while the output stalls; a block
// end adds the clipped tail results, a short block gives one rejected
// word. The output register lets the next sample be taken while the last
// word still waits. The user must write the window length through
// cfg_we_i/cfg_data_i only between words; the block does not enforce this. Values below 3 are ignored.
// ----------------------------------------------------------------------------
`include "centered_moving_average_block_assert.svh"

module centered_moving_average_block #(
  parameter int MAX_HALF = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cma_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cma_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cma_pkg::out_word_t          out_word_o
);
  import cma_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = SAMPLE_W + AW;
  localparam int DIV_W = AW + 1;
  localparam int LW    = CFG_W + 1;
  localparam logic [CFG_W-1:0] LEN_MAX = CFG_W'(2 * MAX_HALF + 1);

  // controller states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_PUT   = 3'd6;

  // result phases of one sample
  localparam logic [1:0] PH_BACK = 2'd0;
  localparam logic [1:0] PH_MAIN = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  logic [2:0]             state_q, state_d;
  logic [CFG_W-1:0]       len_q, len_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic                   end_q, end_d;
  logic                   rej_q, rej_d;
  logic [1:0]             phase_q, phase_d;
  logic [AW-1:0]          r_q, r_d;
  logic [AW-1:0]          k_q, k_d;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] ql1_q, ql1_d;
  logic signed [SUM_W-1:0] q0_q, q0_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] rdata_q;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;

  logic signed [SUM_W-1:0] qmem [DEPTH];

  sample_t                ring_q  [DEPTH];
  sample_t                cell_in [DEPTH];
  sample_t                head_d;
  logic                   ring_en;
  logic                   accept;

  logic [CFG_W-1:0]       half;
  logic [AW-1:0]          half_idx;
  logic [AW-1:0]          len_idx;
  logic [POS_W-1:0]       len_pos;
  logic                   pos_lt;
  logic                   k_hits_l1;
  logic                   tail_last;
  logic [AW-1:0]          count_a;
  logic [SUM_W-1:0]       mag;
  logic                   out_free;
  logic                   rej_word_ok;

  logic                   div_start;
  logic [SUM_W:0]         div_num;
  logic [DIV_W-1:0]       div_den;
  logic                   div_done;
  logic [SAMPLE_W-1:0]    div_quot;

  // window length register: odd, clamped, small writes dropped
  always_comb begin
    len_d = len_q;
    if (cfg_we_i && (cfg_data_i >= LEN_MIN)) begin
      len_d = cfg_data_i | CFG_W'(1);
      if (len_d > LEN_MAX) begin
        len_d = LEN_MAX;
      end
    end
  end

  // derived window quantities
  assign half      = len_q >> 1;
  assign half_idx  = AW'(half);
  assign len_idx   = AW'(len_q);
  assign len_pos   = POS_W'(len_q);
  assign pos_lt    = (pos_q < len_pos);
  assign k_hits_l1 = (LW'(k_q) == (LW'(len_q) + LW'(1)));
  assign tail_last = (r_q == (half_idx + AW'(1)));
  assign count_a   = AW'(LW'(len_q) + LW'(1) - LW'(r_q));
  assign out_free  = !out_valid_q || !out_stall_i;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // sample ring: new sample at the head on accept, wrap-around in a pass
  assign ring_en = accept || (state_q == ST_PASS);
  assign head_d  = (state_q == ST_IDLE) ? in_word_i.sample : ring_q[DEPTH-1];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ring
    if (gi == 0) begin : g_head
      assign cell_in[gi] = head_d;
    end else begin : g_link
      assign cell_in[gi] = ring_q[gi-1];
    end
    cma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_en),
      .d_i     (cell_in[gi]),
      .q_o     (ring_q[gi])
    );
  end

  // suffix sum memory: entry k holds the sum of history offsets k and older
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PASS) begin
      qmem[k_q] <= acc_d;
    end
    rdata_q <= qmem[r_q];
  end

  // divider operands: 2*|sum| + n over 2*n rounds half away from zero
  assign mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_num   = {mag, 1'b0} + (SUM_W + 1)'(cnt_q);
  assign div_den   = {cnt_q, 1'b0};
  assign div_start = (state_q == ST_START);

  cma_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // main sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    end_d       = end_q;
    rej_d       = rej_q;
    phase_d     = phase_q;
    r_d         = r_q;
    k_d         = k_q;
    acc_d       = acc_q;
    ql1_d       = ql1_q;
    q0_d        = q0_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_d = '0;
          ql1_d = '0;
          k_d   = AW'(DEPTH - 1);
          end_d = in_word_i.block_end;
          if (pos_lt) begin
            if (in_word_i.block_end) begin
              pos_d   = '0;
              rej_d   = 1'b1;
              state_d = ST_PUT;
            end else begin
              pos_d = pos_q + POS_W'(1);
            end
          end else begin
            if (in_word_i.block_end) begin
              pos_d = '0;
            end else if (pos_q != POS_MAX) begin
              pos_d = pos_q + POS_W'(1);
            end
            // backlog release only when the block just outgrew the window
            if (pos_q == len_pos) begin
              phase_d = PH_BACK;
              r_d     = half_idx + AW'(1);
            end else begin
              phase_d = PH_MAIN;
              r_d     = len_idx;
            end
            state_d = ST_PASS;
          end
        end
      end

      ST_PASS: begin
        acc_d = acc_q + SUM_W'(ring_q[DEPTH-1]);
        k_d   = k_q - AW'(1);
        if (k_hits_l1) begin
          ql1_d = acc_d;
        end
        if (k_q == '0) begin
          q0_d    = acc_d;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        state_d = ST_DIFF;
      end

      ST_DIFF: begin
        // backlog windows end at the oldest sample, the rest start at the newest
        if (phase_q == PH_BACK) begin
          sum_d = rdata_q - ql1_q;
          cnt_d = count_a;
        end else begin
          sum_d = q0_q - rdata_q;
          cnt_d = r_q;
        end
        state_d = ST_START;
      end

      ST_START: begin
        neg_d   = sum_q[SUM_W-1];
        state_d = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rej_q) begin
            out_word_d.average      = '0;
            out_word_d.final_result = 1'b1;
            out_word_d.rejected     = 1'b1;
            rej_d                   = 1'b0;
            state_d                 = ST_IDLE;
          end else begin
            out_word_d.average      = neg_q ? SAMPLE_W'(-div_quot) : div_quot;
            out_word_d.final_result = (phase_q == PH_TAIL) && tail_last;
            out_word_d.rejected     = 1'b0;
            state_d                 = ST_READ;
            unique case (phase_q)
              PH_BACK: begin
                if (r_q == AW'(1)) begin
                  phase_d = PH_MAIN;
                  r_d     = len_idx;
                end else begin
                  r_d = r_q - AW'(1);
                end
              end
              PH_MAIN: begin
                if (end_q) begin
                  phase_d = PH_TAIL;
                  r_d     = len_idx - AW'(1);
                end else begin
                  state_d = ST_IDLE;
                end
              end
              PH_TAIL: begin
                if (tail_last) begin
                  state_d = ST_IDLE;
                end else begin
                  r_d = r_q - AW'(1);
                end
              end
              default: begin
                state_d = ST_IDLE;
              end
            endcase
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      pos_q       <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    phase_q    <= phase_d;
    r_q        <= r_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
    ql1_q      <= ql1_d;
    q0_q       <= q0_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // checks
  assign rej_word_ok = !(out_valid_o && out_word_o.rejected) ||
                       (out_word_o.final_result && (out_word_o.average == '0));

  `CMA_ASSERT_HOLDS(a_rej_word, rej_word_ok, "rejected word must be final with zero average")
  `CMA_ASSERT_HOLDS(a_div_done, !div_done || state_q == ST_DIV, "divider done outside wait")
  `CMA_ASSERT_NEXT(a_long_pass, accept && !pos_lt, state_q == ST_PASS, "no ring pass started")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for centered_moving_average_block. Blocks of random
// samples go in through a queue-fed driver. A predictor follows each accepted
// word and queues the averages it should release. A monitor compares every
// output word field by field. Both channels idle and stall at random, and the
// window length is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import cma_pkg::*;

  localparam int MAX_HALF  = 31;
  localparam int HIST_N    = 2 * MAX_HALF + 2;
  localparam int RING_CYC  = 2 * MAX_HALF + 2;
  localparam int DIV_CYC   = SAMPLE_W + 4;
  localparam int WORD_CYC  = 2 * MAX_HALF + SAMPLE_W + 7;
  localparam int DRAIN_CYC = 2 * WORD_CYC;
  localparam int MAX_RES   = 64;
  localparam int MAX_IDLE  = 40;
  localparam int RAND_WORDS = 430;
  localparam int MAX_WORDS  = 700;
  localparam longint CYCLE_LIMIT =
    3 * longint'(MAX_WORDS) * (RING_CYC + MAX_RES * (DIV_CYC + MAX_IDLE) + MAX_IDLE);

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block ports
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_word_o;

  centered_moving_average_block #(
    .MAX_HALF(MAX_HALF)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // predictor state: history newest first, position in block, window length
  sample_t          hist [HIST_N];
  int unsigned      blk_pos = 0;
  int unsigned      win_len = LEN_RESET;

  in_word_t         sample_queue [$];
  out_word_t        avg_due [$];
  int unsigned      words_pushed   = 0;
  int unsigned      words_accepted = 0;
  int unsigned      err_cnt        = 0;
  longint unsigned  cycle_cnt      = 0;

  // rounded mean of history offsets a..b, half away from zero
  function automatic sample_t clipped_mean(input int unsigned a, input int unsigned b);
    longint acc;
    longint cnt;
    longint q;
    acc = 0;
    for (int unsigned k = a; k <= b; k++) acc += hist[k];
    cnt = longint'(b - a + 1);
    if (acc >= 0) begin
      q = (2 * acc + cnt) / (2 * cnt);
    end else begin
      q = -((2 * (-acc) + cnt) / (2 * cnt));
    end
    return sample_t'(q);
  endfunction

  function automatic void queue_avg(input sample_t avg, input logic fin, input logic rej);
    out_word_t w;
    w.average      = avg;
    w.final_result = fin;
    w.rejected     = rej;
    avg_due.push_back(w);
  endfunction

  // averages released by one accepted sample word
  function automatic void predict_averages(input in_word_t w);
    int unsigned len;
    int unsigned half;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    len  = win_len;
    half = len >> 1;
    pos  = blk_pos;
    for (int k = HIST_N - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = w.sample;

    // block not yet longer than the window
    if (pos < len) begin
      if (w.block_end) begin
        queue_avg('0, 1'b1, 1'b1);
        blk_pos = 0;
      end else begin
        blk_pos = pos + 1;
      end
      return;
    end

    if (pos == len) begin
      // backlog from block start; sample j sits at offset len-j
      for (int unsigned i = 0; i <= half + 1; i++) begin
        lo = (i > half) ? i - half : 0;
        hi = i + half;
        if (hi > len) hi = len;
        queue_avg(clipped_mean(len - hi, len - lo), 1'b0, 1'b0);
      end
    end else begin
      queue_avg(clipped_mean(0, 2 * half), 1'b0, 1'b0);
    end

    if (w.block_end) begin
      // clipped tail, centers half-1 .. 0 samples back
      for (int c = int'(half) - 1; c >= 0; c--) begin
        queue_avg(clipped_mean(0, c + half), c == 0, 1'b0);
      end
      blk_pos = 0;
    end else begin
      blk_pos = (pos + 1 > POS_MAX) ? POS_MAX : pos + 1;
    end
  endfunction

  // idle length: mostly short, few long, with calm stretches of no idling
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_IDLE);
  endfunction

  // input driver
  int in_gap  = 0;
  int in_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      in_gap     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_averages(in_word_i);
        words_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_word_i  <= sample_queue.pop_front();
          in_valid_i <= 1'b1;
          in_gap     = pick_idle(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  int        out_hold = 0;
  int        out_calm = 0;
  int        out_len;
  out_word_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (avg_due.size() == 0) begin
          $error("unexpected word: average %0d final_result %0b rejected %0b",
                 out_word_o.average, out_word_o.final_result, out_word_o.rejected);
          err_cnt++;
        end else begin
          want = avg_due.pop_front();
          if (out_word_o.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, out_word_o.average);
            err_cnt++;
          end
          if (out_word_o.final_result !== want.final_result) begin
            $error("final_result: expected %0b, got %0b",
                   want.final_result, out_word_o.final_result);
            err_cnt++;
          end
          if (out_word_o.rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, out_word_o.rejected);
            err_cnt++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_len = pick_idle(out_calm);
        if (out_len > 0) begin
          out_hold = out_len - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[centered_moving_average_block] ERROR");
      $finish;
    end
  end

  // stimulus helpers
  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return sample_t'(16'sh7fff);
    if (r < 15) return sample_t'(16'sh8000);
    if (r < 40) return sample_t'($signed($urandom_range(0, 8)) - 4);
    return sample_t'($urandom);
  endfunction

  task automatic push_word(input sample_t s, input logic e);
    in_word_t w;
    w.sample    = s;
    w.block_end = e;
    sample_queue.push_back(w);
    words_pushed++;
  endtask

  // n words, the last one closing the block
  task automatic push_block(input int n);
    for (int i = 0; i < n; i++) push_word(rand_sample(), i == n - 1);
  endtask

  // n words, block left open
  task automatic push_open(input int n);
    for (int i = 0; i < n; i++) push_word(rand_sample(), 1'b0);
  endtask

  // every word accepted and every average delivered, then let the block settle
  task automatic settle();
    do @(posedge clk_i);
    while (words_accepted != words_pushed || avg_due.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (v >= LEN_MIN) win_len = v | 1;
  endtask

  int unsigned rand_base;
  int          blocks;
  int          n;
  int          r;

  initial begin
    foreach (hist[k]) hist[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short blocks, extremes, edge rounding at the reset window of 3
    push_word(16'sh7fff, 1'b1);
    push_word(16'sh8000, 1'b0);
    push_word(16'sh0000, 1'b0);
    push_word(16'sh0001, 1'b1);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh8000, 1'b0);
    push_word(16'sh8000, 1'b1);
    push_word(-16'sd1, 1'b0);
    push_word(16'sd0, 1'b0);
    push_word(16'sd5, 1'b0);
    push_word(-16'sd6, 1'b0);
    push_word(16'sd0, 1'b0);
    push_word(16'sd1, 1'b1);
    settle();

    // too-small lengths are dropped, then 4 becomes 5
    write_len(CFG_W'(0));
    write_len(CFG_W'(2));
    write_len(CFG_W'(4));

    // shrink the window past the position: no backlog release
    push_open(4);
    settle();
    write_len(CFG_W'(3));
    push_block(2);

    // grow then shrink so the position lands on the length
    push_open(2);
    settle();
    write_len(CFG_W'(7));
    push_open(1);
    settle();
    write_len(CFG_W'(3));
    push_block(2);
    settle();

    // random: widest window first, then a saturating long block at the narrowest
    rand_base = words_pushed;
    write_len(CFG_W'(63));
    push_block(64 + $urandom_range(0, 6));
    push_block($urandom_range(1, 8));
    settle();
    write_len(CFG_W'(3));
    push_block(140);
    push_block($urandom_range(1, 3));

    while (words_pushed - rand_base < RAND_WORDS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 50)      write_len(CFG_W'($urandom_range(3, 11)));
      else if (r < 80) write_len(CFG_W'($urandom_range(0, 63)));
      else if (r < 90) write_len(CFG_W'($urandom_range(0, 2)));
      else             write_len(CFG_W'($urandom_range(12, 31)));
      blocks = $urandom_range(1, 4);
      for (int b = 0; b < blocks; b++) begin
        r = $urandom_range(0, 99);
        if (r < 15)      n = $urandom_range(1, win_len);
        else if (r < 25) n = win_len + 1;
        else             n = win_len + 1 + $urandom_range(0, 12);
        n = n - int'(blk_pos);
        if (n < 1) n = 1;
        if (b == blocks - 1 && $urandom_range(0, 99) < 20) begin
          // leave the block open across the next length write
          push_open($urandom_range(1, n));
        end else begin
          push_block(n);
        end
      end
    end

    settle();
    if (err_cnt == 0 && avg_due.size() == 0) begin
      $display("[centered_moving_average_block] OK");
    end else begin
      $display("[centered_moving_average_block] ERROR");
    end
    $finish;
  end

endmodule
